// ===== src/rc2_block_cipher_core_macros.svh =====
// ----------------------------------------------------------------------------
// rc2 block cipher core assertion macros
// shared concurrent assertion forms for the cipher core
// ----------------------------------------------------------------------------
`ifndef RC2_BLOCK_CIPHER_CORE_MACROS_SVH
`define RC2_BLOCK_CIPHER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RC2_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// next-cycle implication, disabled during reset
`define RC2_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== src/rc2_pkg.sv =====
// ----------------------------------------------------------------------------
// rc2 package
// types, codes and the pi permutation for the rc2 cipher core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc2_pkg;

    localparam int TABLE_BYTES = 128;
    localparam int TABLE_AW    = $clog2(TABLE_BYTES);
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int BLOCK_W     = 64;
    localparam int LEN_W       = TABLE_AW + 1;

    localparam logic [LEN_W-1:0]    KEY_FULL   = LEN_W'(TABLE_BYTES);
    localparam logic [TABLE_AW-1:0] LAST_INDEX = TABLE_AW'(TABLE_BYTES - 1);

    localparam logic [3:0] ENC_FIRST_ROUND  = 4'd0;
    localparam logic [3:0] ENC_LAST_ROUND   = 4'd15;
    localparam logic [3:0] DEC_FIRST_ROUND  = 4'd15;
    localparam logic [3:0] DEC_LAST_ROUND   = 4'd0;
    localparam logic [3:0] ENC_MASH_ROUND_A = 4'd4;
    localparam logic [3:0] ENC_MASH_ROUND_B = 4'd10;
    localparam logic [3:0] DEC_MASH_ROUND_A = 4'd11;
    localparam logic [3:0] DEC_MASH_ROUND_B = 4'd5;
    localparam logic [1:0] ENC_FIRST_WORD   = 2'd0;
    localparam logic [1:0] ENC_LAST_WORD    = 2'd3;
    localparam logic [1:0] DEC_FIRST_WORD   = 2'd3;
    localparam logic [1:0] DEC_LAST_WORD    = 2'd0;

    typedef enum logic [1:0] {
        OP_KEY = 2'd0,
        OP_ENC = 2'd1,
        OP_DEC = 2'd2,
        OP_NOP = 2'd3
    } rc2_op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_KEY   = 2'd1,
        STAT_KEY_LONG = 2'd2
    } rc2_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_WR,
        S_RND_RD,
        S_RND_EX,
        S_RESULT
    } rc2_state_t;

    typedef enum logic [1:0] {
        PH_FWD,
        PH_MID,
        PH_BWD
    } rc2_phase_t;

    typedef struct packed {
        rc2_op_t              operation;
        logic [BYTE_W-1:0]    key_byte;
        logic                 key_last;
        logic [BLOCK_W-1:0]   block_in;
    } rc2_cmd_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]   block_out;
        rc2_status_t          status;
    } rc2_res_t;

    localparam logic [BYTE_W-1:0] PI_TABLE [256] = '{
        8'hd9, 8'h78, 8'hf9, 8'hc4, 8'h19, 8'hdd, 8'hb5, 8'hed,
        8'h28, 8'he9, 8'hfd, 8'h79, 8'h4a, 8'ha0, 8'hd8, 8'h9d,
        8'hc6, 8'h7e, 8'h37, 8'h83, 8'h2b, 8'h76, 8'h53, 8'h8e,
        8'h62, 8'h4c, 8'h64, 8'h88, 8'h44, 8'h8b, 8'hfb, 8'ha2,
        8'h17, 8'h9a, 8'h59, 8'hf5, 8'h87, 8'hb3, 8'h4f, 8'h13,
        8'h61, 8'h45, 8'h6d, 8'h8d, 8'h09, 8'h81, 8'h7d, 8'h32,
        8'hbd, 8'h8f, 8'h40, 8'heb, 8'h86, 8'hb7, 8'h7b, 8'h0b,
        8'hf0, 8'h95, 8'h21, 8'h22, 8'h5c, 8'h6b, 8'h4e, 8'h82,
        8'h54, 8'hd6, 8'h65, 8'h93, 8'hce, 8'h60, 8'hb2, 8'h1c,
        8'h73, 8'h56, 8'hc0, 8'h14, 8'ha7, 8'h8c, 8'hf1, 8'hdc,
        8'h12, 8'h75, 8'hca, 8'h1f, 8'h3b, 8'hbe, 8'he4, 8'hd1,
        8'h42, 8'h3d, 8'hd4, 8'h30, 8'ha3, 8'h3c, 8'hb6, 8'h26,
        8'h6f, 8'hbf, 8'h0e, 8'hda, 8'h46, 8'h69, 8'h07, 8'h57,
        8'h27, 8'hf2, 8'h1d, 8'h9b, 8'hbc, 8'h94, 8'h43, 8'h03,
        8'hf8, 8'h11, 8'hc7, 8'hf6, 8'h90, 8'hef, 8'h3e, 8'he7,
        8'h06, 8'hc3, 8'hd5, 8'h2f, 8'hc8, 8'h66, 8'h1e, 8'hd7,
        8'h08, 8'he8, 8'hea, 8'hde, 8'h80, 8'h52, 8'hee, 8'hf7,
        8'h84, 8'haa, 8'h72, 8'hac, 8'h35, 8'h4d, 8'h6a, 8'h2a,
        8'h96, 8'h1a, 8'hd2, 8'h71, 8'h5a, 8'h15, 8'h49, 8'h74,
        8'h4b, 8'h9f, 8'hd0, 8'h5e, 8'h04, 8'h18, 8'ha4, 8'hec,
        8'hc2, 8'he0, 8'h41, 8'h6e, 8'h0f, 8'h51, 8'hcb, 8'hcc,
        8'h24, 8'h91, 8'haf, 8'h50, 8'ha1, 8'hf4, 8'h70, 8'h39,
        8'h99, 8'h7c, 8'h3a, 8'h85, 8'h23, 8'hb8, 8'hb4, 8'h7a,
        8'hfc, 8'h02, 8'h36, 8'h5b, 8'h25, 8'h55, 8'h97, 8'h31,
        8'h2d, 8'h5d, 8'hfa, 8'h98, 8'he3, 8'h8a, 8'h92, 8'hae,
        8'h05, 8'hdf, 8'h29, 8'h10, 8'h67, 8'h6c, 8'hba, 8'hc9,
        8'hd3, 8'h00, 8'he6, 8'hcf, 8'he1, 8'h9e, 8'ha8, 8'h2c,
        8'h63, 8'h16, 8'h01, 8'h3f, 8'h58, 8'he2, 8'h89, 8'ha9,
        8'h0d, 8'h38, 8'h34, 8'h1b, 8'hab, 8'h33, 8'hff, 8'hb0,
        8'hbb, 8'h48, 8'h0c, 8'h5f, 8'hb9, 8'hb1, 8'hcd, 8'h2e,
        8'hc5, 8'hf3, 8'hdb, 8'h47, 8'he5, 8'ha5, 8'h9c, 8'h77,
        8'h0a, 8'ha6, 8'h20, 8'h68, 8'hfe, 8'h7f, 8'hc1, 8'had
    };

endpackage

`default_nettype wire

// ===== src/rc2_ram.sv =====
// ----------------------------------------------------------------------------
// rc2 ram
// generic single write, dual read memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/rc2_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// rc2 block cipher core
// rc2 on 64-bit little-endian blocks with byte-wise key loading
// ----------------------------------------------------------------------------
// Key bytes arrive one per transaction; the byte flagged last starts the
// expansion of the stored key of length L into the 128-byte table, in
// which every table byte is read from the table RAM in S_EXP_RD and written
// back in S_EXP_WR. An encrypt or decrypt block runs one 16-bit round unit
// through one quarter round at a time, 64 mix and 8 mash steps, as each
// step waits in S_RND_RD on the registered read of its key word from the
// table RAM. Other transactions go from idle straight to the result state.
// One transaction is worked on at a time; the result sits in an output
// register, so the next transaction is taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
`include "rc2_block_cipher_core_macros.svh"

module rc2_block_cipher_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire rc2_pkg::rc2_cmd_t cmd,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output rc2_pkg::rc2_res_t    res
);

    import rc2_pkg::*;

    rc2_state_t           state_reg, state_next;
    logic [LEN_W-1:0]     key_length_reg, key_length_next;
    logic                 key_ready_reg, key_ready_next;
    logic [TABLE_AW-1:0]  exp_len_reg, exp_len_next;
    logic [TABLE_AW-1:0]  idx_reg, idx_next;
    rc2_phase_t           phase_reg, phase_next;
    logic [3:0]           rnd_reg, rnd_next;
    logic [1:0]           qtr_reg, qtr_next;
    logic                 mash_reg, mash_next;
    logic                 dec_reg, dec_next;
    logic [WORD_W-1:0]    s0_reg, s0_next;
    logic [WORD_W-1:0]    s1_reg, s1_next;
    logic [WORD_W-1:0]    s2_reg, s2_next;
    logic [WORD_W-1:0]    s3_reg, s3_next;
    rc2_status_t          status_reg, status_next;
    logic                 res_valid_reg, res_valid_next;
    rc2_res_t             res_reg, res_next;

    logic                 cmd_accept;
    logic                 res_free;
    logic                 key_full;
    logic [LEN_W-1:0]     key_len_new;
    logic                 ram_we;
    logic [TABLE_AW-1:0]  ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;
    logic [TABLE_AW-1:0]  ram_raddr_a;
    logic [TABLE_AW-1:0]  ram_raddr_b;
    logic [BYTE_W-1:0]    ram_rdata_a;
    logic [BYTE_W-1:0]    ram_rdata_b;
    logic [BYTE_W-1:0]    exp_index;
    logic [BYTE_W-1:0]    exp_byte;
    logic                 exp_done;
    logic [5:0]           kword_sel;
    logic [WORD_W-1:0]    kword;
    logic [WORD_W-1:0]    mix_term;
    logic [WORD_W-1:0]    rotr_val;
    logic [WORD_W-1:0]    add_a;
    logic [WORD_W-1:0]    add_b;
    logic [WORD_W-1:0]    sum_val;
    logic [WORD_W-1:0]    rotl_val;
    logic [WORD_W-1:0]    step_val;
    logic                 last_q;
    logic                 last_round;
    logic                 mash_round;
    logic                 rnd_done;
    logic [BLOCK_W-1:0]   block_unload;

    assign cmd_stall   = (state_reg != S_IDLE);
    assign cmd_accept  = cmd_valid && !cmd_stall;
    assign res_free    = !res_valid_reg || !res_stall;
    assign key_full    = (key_length_reg == KEY_FULL);
    assign key_len_new = key_full ? key_length_reg : key_length_reg + LEN_W'(1);

    // key table
    rc2_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_BYTES)
    ) u_key_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // expansion byte
    always_comb
    begin
        unique case (phase_reg)
            PH_FWD:  exp_index = ram_rdata_a + ram_rdata_b;
            PH_MID:  exp_index = ram_rdata_a;
            PH_BWD:  exp_index = ram_rdata_a ^ ram_rdata_b;
            default: exp_index = ram_rdata_a;
        endcase
    end

    assign exp_byte = PI_TABLE[exp_index];
    assign exp_done = (idx_reg == '0) && ((phase_reg == PH_MID) || (phase_reg == PH_BWD));

    // round unit
    assign kword_sel = mash_reg ? s3_reg[5:0] : {rnd_reg, qtr_reg};
    assign kword     = {ram_rdata_b, ram_rdata_a};
    assign mix_term  = kword + (s3_reg & s2_reg) + (~s3_reg & s1_reg);

    always_comb
    begin
        unique case (qtr_reg)
            2'd0:    rotr_val = {s0_reg[0],   s0_reg[15:1]};
            2'd1:    rotr_val = {s0_reg[1:0], s0_reg[15:2]};
            2'd2:    rotr_val = {s0_reg[2:0], s0_reg[15:3]};
            default: rotr_val = {s0_reg[4:0], s0_reg[15:5]};
        endcase
    end

    assign add_a   = (dec_reg && !mash_reg) ? rotr_val : s0_reg;
    assign add_b   = mash_reg ? kword : mix_term;
    assign sum_val = dec_reg ? add_a - add_b : add_a + add_b;

    always_comb
    begin
        unique case (qtr_reg)
            2'd0:    rotl_val = {sum_val[14:0], sum_val[15]};
            2'd1:    rotl_val = {sum_val[13:0], sum_val[15:14]};
            2'd2:    rotl_val = {sum_val[12:0], sum_val[15:13]};
            default: rotl_val = {sum_val[10:0], sum_val[15:11]};
        endcase
    end

    assign step_val   = (!dec_reg && !mash_reg) ? rotl_val : sum_val;
    assign last_q     = dec_reg ? (qtr_reg == DEC_LAST_WORD) : (qtr_reg == ENC_LAST_WORD);
    assign last_round = dec_reg ? (rnd_reg == DEC_LAST_ROUND) : (rnd_reg == ENC_LAST_ROUND);
    assign mash_round = dec_reg
        ? ((rnd_reg == DEC_MASH_ROUND_A) || (rnd_reg == DEC_MASH_ROUND_B))
        : ((rnd_reg == ENC_MASH_ROUND_A) || (rnd_reg == ENC_MASH_ROUND_B));
    assign rnd_done   = last_q && last_round;

    assign block_unload = dec_reg ? {s0_reg, s3_reg, s2_reg, s1_reg}
                                  : {s3_reg, s2_reg, s1_reg, s0_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    priority if (cmd.operation == OP_KEY && cmd.key_last)
                    begin
                        state_next = S_EXP_RD;
                    end
                    else if ((cmd.operation == OP_ENC || cmd.operation == OP_DEC)
                             && key_ready_reg)
                    begin
                        state_next = S_RND_RD;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_EXP_RD: state_next = S_EXP_WR;
            S_EXP_WR: state_next = exp_done ? S_RESULT : S_EXP_RD;
            S_RND_RD: state_next = S_RND_EX;
            S_RND_EX: state_next = rnd_done ? S_RESULT : S_RND_RD;
            S_RESULT: state_next = res_free ? S_IDLE : S_RESULT;
            default:  state_next = S_IDLE;
        endcase
    end

    // table ram control
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = exp_byte;
        ram_raddr_a = idx_reg;
        ram_raddr_b = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_we    = cmd_accept && (cmd.operation == OP_KEY) && !key_full;
                ram_waddr = key_length_reg[TABLE_AW-1:0];
                ram_wdata = cmd.key_byte;
            end
            S_EXP_RD:
            begin
                unique case (phase_reg)
                    PH_FWD:
                    begin
                        ram_raddr_a = idx_reg - TABLE_AW'(1);
                        ram_raddr_b = idx_reg - exp_len_reg;
                    end
                    PH_BWD:
                    begin
                        ram_raddr_a = idx_reg + TABLE_AW'(1);
                        ram_raddr_b = idx_reg + exp_len_reg;
                    end
                    default:
                    begin
                        ram_raddr_a = idx_reg;
                        ram_raddr_b = idx_reg;
                    end
                endcase
            end
            S_EXP_WR:
            begin
                ram_we = 1'b1;
            end
            S_RND_RD:
            begin
                ram_raddr_a = {kword_sel, 1'b0};
                ram_raddr_b = {kword_sel, 1'b1};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        key_length_next = key_length_reg;
        key_ready_next  = key_ready_reg;
        exp_len_next    = exp_len_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        rnd_next        = rnd_reg;
        qtr_next        = qtr_reg;
        mash_next       = mash_reg;
        dec_next        = dec_reg;
        s0_next         = s0_reg;
        s1_next         = s1_reg;
        s2_next         = s2_reg;
        s3_next         = s3_reg;
        status_next     = status_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    status_next = STAT_OK;
                    dec_next    = 1'b0;
                    mash_next   = 1'b0;
                    s0_next     = '0;
                    s1_next     = '0;
                    s2_next     = '0;
                    s3_next     = '0;
                    unique case (cmd.operation)
                        OP_KEY:
                        begin
                            key_ready_next = 1'b0;
                            if (key_full)
                            begin
                                status_next = STAT_KEY_LONG;
                            end
                            if (cmd.key_last)
                            begin
                                key_length_next = '0;
                                exp_len_next    = key_len_new[TABLE_AW-1:0];
                                if (key_len_new == KEY_FULL)
                                begin
                                    phase_next = PH_MID;
                                    idx_next   = '0;
                                end
                                else
                                begin
                                    phase_next = PH_FWD;
                                    idx_next   = key_len_new[TABLE_AW-1:0];
                                end
                            end
                            else
                            begin
                                key_length_next = key_len_new;
                            end
                        end
                        OP_ENC, OP_DEC:
                        begin
                            if (!key_ready_reg)
                            begin
                                status_next = STAT_NO_KEY;
                            end
                            else if (cmd.operation == OP_ENC)
                            begin
                                rnd_next = ENC_FIRST_ROUND;
                                qtr_next = ENC_FIRST_WORD;
                                s0_next  = cmd.block_in[15:0];
                                s1_next  = cmd.block_in[31:16];
                                s2_next  = cmd.block_in[47:32];
                                s3_next  = cmd.block_in[63:48];
                            end
                            else
                            begin
                                dec_next = 1'b1;
                                rnd_next = DEC_FIRST_ROUND;
                                qtr_next = DEC_FIRST_WORD;
                                s0_next  = cmd.block_in[63:48];
                                s1_next  = cmd.block_in[15:0];
                                s2_next  = cmd.block_in[31:16];
                                s3_next  = cmd.block_in[47:32];
                            end
                        end
                        OP_NOP:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_EXP_WR:
            begin
                unique case (phase_reg)
                    PH_FWD:
                    begin
                        if (idx_reg == LAST_INDEX)
                        begin
                            phase_next = PH_MID;
                            idx_next   = TABLE_AW'(0) - exp_len_reg;
                        end
                        else
                        begin
                            idx_next = idx_reg + TABLE_AW'(1);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_BWD;
                        idx_next   = idx_reg - TABLE_AW'(1);
                    end
                endcase
                if (exp_done)
                begin
                    key_ready_next = 1'b1;
                end
            end
            S_RND_EX:
            begin
                if (dec_reg)
                begin
                    s0_next  = s3_reg;
                    s1_next  = step_val;
                    s2_next  = s1_reg;
                    s3_next  = s2_reg;
                    qtr_next = qtr_reg - 2'd1;
                end
                else
                begin
                    s0_next  = s1_reg;
                    s1_next  = s2_reg;
                    s2_next  = s3_reg;
                    s3_next  = step_val;
                    qtr_next = qtr_reg + 2'd1;
                end
                if (last_q)
                begin
                    if (!mash_reg && mash_round)
                    begin
                        mash_next = 1'b1;
                    end
                    else
                    begin
                        mash_next = 1'b0;
                        rnd_next  = dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    end
                end
            end
            S_RESULT:
            begin
                if (res_free)
                begin
                    res_valid_next    = 1'b1;
                    res_next.block_out = block_unload;
                    res_next.status    = status_reg;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            key_length_reg <= '0;
            key_ready_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            key_length_reg <= key_length_next;
            key_ready_reg  <= key_ready_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        exp_len_reg <= exp_len_next;
        idx_reg     <= idx_next;
        phase_reg   <= phase_next;
        rnd_reg     <= rnd_next;
        qtr_reg     <= qtr_next;
        mash_reg    <= mash_next;
        dec_reg     <= dec_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        s3_reg      <= s3_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `RC2_ASSERT_IMPL(a_rounds_need_key, clk, rst_n, (state_reg == S_RND_RD) || (state_reg == S_RND_EX), key_ready_reg, "cipher rounds running without an expanded key")
    `RC2_ASSERT_IMPL(a_ready_from_expansion, clk, rst_n, $rose(key_ready_reg), $past(state_reg) == S_EXP_WR, "key ready raised outside key expansion")
    `RC2_ASSERT_NEXT(a_key_byte_clears_ready, clk, rst_n, cmd_accept && (cmd.operation == OP_KEY), !key_ready_reg, "key byte transaction left key ready set")

endmodule

`default_nettype wire
